@@ rtl/core/tprp_pkg.sv @@
`timescale 1ns / 1ps

package tprp_pkg;

   // Default number of pattern store entries (entry 0 holds the length).
   localparam int DEF_STORE_DEPTH = 256;

   // Register reset values.
   localparam logic [15:0] HOLD_TICKS_RESET  = 16'd1000;
   localparam logic [7:0]  BLINK_LIMIT_RESET = 8'd10;
   localparam logic [7:0]  MAX_BYTES_RESET   = 8'd255;

   // Configuration port geometry and register indexes.
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_HOLD_TICKS  = 2'd0;
   localparam logic [1:0] REG_BLINK_LIMIT = 2'd1;
   localparam logic [1:0] REG_MAX_BYTES   = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_WREL   = 3'd1,
      MODE_WPRESS = 3'd2,
      MODE_REC    = 3'd3,
      MODE_PLAY   = 3'd4
   } mode_type;

   typedef struct packed {
      logic [15:0] hold_ticks;
      logic [7:0]  blink_limit;
      logic [7:0]  max_bytes;
   } cfg_type;

   // Packed so that pattern_light lands in bit 0 of the response data.
   typedef struct packed {
      logic [7:0] stored_length;
      mode_type   mode_code;
      logic       status_light;
      logic       pattern_light;
   } rsp_type;

endpackage

@@ rtl/core/tick_pattern_record_playback_core.sv @@
`timescale 1ns / 1ps

// Tick-driven pattern recorder and player.
// Every request on the req_ stream is one timer tick carrying the raw,
// active-low levels of the program, action and trigger pins. Each request
// yields exactly one response on the rsp_ stream with both light levels,
// the current mode and the stored pattern length.
// An accepted request has its response registered and on rsp_tvalid in the
// cycle after. Throughput is one request per cycle while the receiver
// takes responses; the tick state registers get a combinational
// read-modify-write, and pattern bytes come from a one-port-read store
// whose next byte is fetched ahead, eight ticks before it is shown.
// The response sits in an output register, so a new request is taken
// whenever that register is empty or being drained in the same cycle.
// When the receiver stalls, the response is held and req_tready drops
// until it is taken; nothing is lost or repeated.
// Reset (synchronous, active high) returns the block to idle with the
// lights low, the stored length zero and the registers at their defaults.
// No clearing pass is needed: store entries are only read after the
// recording that wrote them. The user writes the registers over the csr_ port
// only while no request is in flight; the block does not enforce this.
module tick_pattern_record_playback_core
   import tprp_pkg::*;
#(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Bits from the lowest: program_pin, action_pin, trigger_pin, zero pad.
   input  logic [7:0]            req_tdata,
   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Bits from the lowest: pattern_light, status_light, mode_code[2:0],
   // stored_length[7:0], zero pad.
   output logic [15:0]           rsp_tdata,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   rsp_type result;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   logic    req_fire;

   // A request is taken when the output register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   tprp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tprp_engine #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (req_fire),
      .program_pin (req_tdata[0]),
      .action_pin  (req_tdata[1]),
      .trigger_pin (req_tdata[2]),
      .cfg         (cfg),
      .result      (result)
   );

   // Output register: loaded on every accepted request, emptied when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff};

`ifndef SYNTHESIS
   // Every accepted request leaves a response in the output register.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // Playback only runs with a nonzero stored length.
   a_play_has_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.mode_code == MODE_PLAY)
         |-> rsp_data_ff.stored_length != 8'd0)
      else $error("playing with an empty pattern");

   // While armed, the status light is on and the pattern light is off.
   a_armed_lights: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_data_ff.mode_code == MODE_WREL ||
                      rsp_data_ff.mode_code == MODE_WPRESS))
         |-> (rsp_data_ff.status_light && !rsp_data_ff.pattern_light))
      else $error("armed indication wrong");

   // In idle only the status light may blink.
   a_idle_pattern_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.mode_code == MODE_IDLE)
         |-> !rsp_data_ff.pattern_light)
      else $error("pattern light on while idle");
`endif

endmodule

@@ rtl/core/tprp_ram.sv @@
`timescale 1ns / 1ps

module tprp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tprp_csr.sv @@
`timescale 1ns / 1ps

module tprp_csr
   import tprp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [1:0] index;
   logic       wr_fire;

   assign index   = csr_paddr[3:2];
   assign wr_fire = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks  <= HOLD_TICKS_RESET;
         cfg_ff.blink_limit <= BLINK_LIMIT_RESET;
         cfg_ff.max_bytes   <= MAX_BYTES_RESET;
      end else if (wr_fire) begin
         case (index)
            REG_HOLD_TICKS:  cfg_ff.hold_ticks  <= csr_pwdata[15:0];
            REG_BLINK_LIMIT: cfg_ff.blink_limit <= csr_pwdata[7:0];
            REG_MAX_BYTES:   cfg_ff.max_bytes   <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_HOLD_TICKS:  csr_prdata = {16'd0, cfg_ff.hold_ticks};
         REG_BLINK_LIMIT: csr_prdata = {24'd0, cfg_ff.blink_limit};
         REG_MAX_BYTES:   csr_prdata = {24'd0, cfg_ff.max_bytes};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

@@ rtl/core/tprp_engine.sv @@
`timescale 1ns / 1ps

module tprp_engine
   import tprp_pkg::*;
#(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    program_pin,
   input  logic    action_pin,
   input  logic    trigger_pin,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [AW-1:0] ADDR_ZERO = '0;
   localparam logic [AW-1:0] ADDR_ONE  = AW'(1);
   localparam logic [AW-1:0] ADDR_LAST = AW'(STORE_DEPTH - 1);

   logic [2:0]    prev_raw_ff,   prev_raw_in;
   logic [15:0]   hold_count_ff, hold_count_in;
   logic [7:0]    blink_count_ff, blink_count_in;
   mode_type      mode_ff,       mode_in;
   logic [2:0]    bit_index_ff,  bit_index_in;
   logic [7:0]    shift_byte_ff, shift_byte_in;
   logic [7:0]    byte_count_ff, byte_count_in;
   logic [AW-1:0] addr_ff,       addr_in;
   logic [7:0]    length_ff,     length_in;
   logic [7:0]    first_byte_ff, first_byte_in;
   logic [1:0]    light_ff,      light_in;

   logic [2:0]    raw;
   logic [2:0]    pressed;
   logic          prog, act, want;
   logic          do_rec, do_play, do_try;
   logic [AW-1:0] next_addr;
   logic [7:0]    rd_data;
   logic [7:0]    next_byte;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   function automatic logic [AW-1:0] addr_incr(input logic [AW-1:0] a);
      addr_incr = (a == ADDR_LAST) ? ADDR_ZERO : a + ADDR_ONE;
   endfunction

   // The next pattern byte is fetched continuously; it only changes when the
   // byte pointer moves, which is eight ticks before the byte is needed.
   assign next_addr = addr_incr(addr_ff);
   assign next_byte = (next_addr == ADDR_ZERO) ? length_ff : rd_data;

   tprp_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (next_addr),
      .rd_data (rd_data)
   );

   assign raw     = {trigger_pin, action_pin, program_pin};
   assign pressed = ~(raw | prev_raw_ff);
   assign prog    = pressed[0];
   assign act     = pressed[1];
   assign want    = pressed[1] | pressed[2];

   always_comb begin
      prev_raw_in    = raw;
      hold_count_in  = hold_count_ff;
      blink_count_in = blink_count_ff;
      mode_in        = mode_ff;
      bit_index_in   = bit_index_ff;
      shift_byte_in  = shift_byte_ff;
      byte_count_in  = byte_count_ff;
      addr_in        = addr_ff;
      length_in      = length_ff;
      first_byte_in  = first_byte_ff;
      light_in       = light_ff;
      do_rec         = 1'b0;
      do_play        = 1'b0;
      do_try         = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = addr_ff;
      wr_data        = shift_byte_ff;

      case (mode_ff)
         MODE_IDLE: begin
            blink_count_in = blink_count_ff + 8'd1;
            if (blink_count_in > cfg.blink_limit) begin
               light_in       = light_ff ^ 2'b10;
               blink_count_in = 8'd0;
            end
            if (prog) begin
               hold_count_in = hold_count_ff + 16'd1;
               if (hold_count_in >= cfg.hold_ticks) begin
                  hold_count_in = 16'd0;
                  light_in      = 2'b10;
                  mode_in       = MODE_WREL;
               end
            end else begin
               hold_count_in = 16'd0;
            end
            do_try = (mode_in == MODE_IDLE);
         end
         MODE_WREL: begin
            if (!prog) begin
               mode_in = MODE_WPRESS;
            end
         end
         MODE_WPRESS: begin
            if (prog) begin
               byte_count_in = 8'd0;
               bit_index_in  = 3'd0;
               shift_byte_in = 8'd0;
               addr_in       = ADDR_ONE;
               mode_in       = MODE_REC;
               do_rec        = 1'b1;
            end
         end
         MODE_REC: begin
            if (bit_index_ff == 3'd0 && (byte_count_ff >= cfg.max_bytes || !prog)) begin
               length_in     = byte_count_ff;
               light_in      = 2'b00;
               hold_count_in = 16'd0;
               mode_in       = MODE_IDLE;
               do_try        = 1'b1;
            end else begin
               do_rec = 1'b1;
            end
         end
         MODE_PLAY: begin
            if (bit_index_ff == 3'd0) begin
               byte_count_in = byte_count_ff + 8'd1;
               if (byte_count_in >= length_ff) begin
                  light_in = 2'b00;
                  mode_in  = MODE_IDLE;
                  do_try   = 1'b1;
               end else begin
                  shift_byte_in = next_byte;
                  addr_in       = next_addr;
                  do_play       = 1'b1;
               end
            end else begin
               do_play = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // One recorded sample; a full byte goes to the store, where entry 0 is
      // the length register and entry 1 is mirrored for playback start.
      if (do_rec) begin
         shift_byte_in = {shift_byte_in[6:0], act};
         light_in      = {act, act};
         bit_index_in  = bit_index_in + 3'd1;
         if (bit_index_in == 3'd0) begin
            wr_en   = step;
            wr_addr = addr_in;
            wr_data = shift_byte_in;
            if (addr_in == ADDR_ZERO) begin
               length_in = shift_byte_in;
            end
            if (addr_in == ADDR_ONE) begin
               first_byte_in = shift_byte_in;
            end
            byte_count_in = byte_count_in + 8'd1;
            addr_in       = addr_incr(addr_in);
         end
      end

      if (do_try && want) begin
         light_in = 2'b00;
         if (length_in != 8'd0) begin
            byte_count_in = 8'd0;
            bit_index_in  = 3'd0;
            shift_byte_in = first_byte_in;
            addr_in       = ADDR_ONE;
            mode_in       = MODE_PLAY;
            do_play       = 1'b1;
         end
      end

      if (do_play) begin
         light_in      = {shift_byte_in[7], shift_byte_in[7]};
         shift_byte_in = {shift_byte_in[6:0], 1'b0};
         bit_index_in  = bit_index_in + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff    <= 3'd0;
         hold_count_ff  <= 16'd0;
         blink_count_ff <= 8'd0;
         mode_ff        <= MODE_IDLE;
         bit_index_ff   <= 3'd0;
         shift_byte_ff  <= 8'd0;
         byte_count_ff  <= 8'd0;
         addr_ff        <= ADDR_ONE;
         length_ff      <= 8'd0;
         first_byte_ff  <= 8'd0;
         light_ff       <= 2'b00;
      end else if (step) begin
         prev_raw_ff    <= prev_raw_in;
         hold_count_ff  <= hold_count_in;
         blink_count_ff <= blink_count_in;
         mode_ff        <= mode_in;
         bit_index_ff   <= bit_index_in;
         shift_byte_ff  <= shift_byte_in;
         byte_count_ff  <= byte_count_in;
         addr_ff        <= addr_in;
         length_ff      <= length_in;
         first_byte_ff  <= first_byte_in;
         light_ff       <= light_in;
      end
   end

   always_comb begin
      result.pattern_light = light_in[0];
      result.status_light  = light_in[1];
      result.mode_code     = mode_in;
      result.stored_length = length_in;
   end

endmodule
